FILE: rtl/core/mfvn_pkg.sv
// mfvn_pkg: shared types and constants for the mesh face and vertex normal block
// no dependencies; used by the channel interfaces and by the top level
package mfvn_pkg;

  // field widths of the request and result channels
  localparam int COORD_W  = 16;
  localparam int IDX_W    = 11;
  localparam int CORNER_W = 10;
  localparam int NORM_W   = 16;
  localparam int AREA_W   = 33;

  // accumulator and arithmetic widths
  localparam int ACC_W    = 40;
  localparam int MUL_W    = ACC_W / 2;
  localparam int SUM_W    = 2 * ACC_W;
  localparam int REM_W    = ACC_W + 1;
  localparam int Q_W      = 15;
  localparam int DIV_W    = ACC_W + Q_W;
  localparam int CNT_W    = 6;

  // default sizes
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_FACES    = 2048;
  localparam int DEF_COORD_BITS   = 16;

  typedef enum logic [1:0] {
    CMD_WR_VTX   = 2'd0,
    CMD_ADD_FACE = 2'd1,
    CMD_RD_VTX   = 2'd2,
    CMD_RD_FACE  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RDA,
    S_RDB,
    S_RDC,
    S_LDC,
    S_XMUL,
    S_XACC,
    S_QMUL,
    S_QACC,
    S_SQI,
    S_SQRT,
    S_DVI,
    S_DIV,
    S_FIN,
    S_ARD,
    S_AWR,
    S_VRD,
    S_VLD,
    S_FRD,
    S_FLD,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/mfvn_if.sv
// mfvn_in_if / mfvn_out_if: valid-ready channels of the mesh normal block
// depends on mfvn_pkg for the field widths
interface mfvn_in_if;
  import mfvn_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [IDX_W-1:0]    index;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [CORNER_W-1:0] corner_a;
  logic [CORNER_W-1:0] corner_b;
  logic [CORNER_W-1:0] corner_c;

  modport source (output valid, command, index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, command, index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface mfvn_out_if;
  import mfvn_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic [AREA_W-1:0]   tri_area;
  logic [CORNER_W-1:0] face_vertex_a;
  logic [CORNER_W-1:0] face_vertex_b;
  logic [CORNER_W-1:0] face_vertex_c;
  logic                valid_res;

  modport source (output valid, normal_x, normal_y, normal_z, tri_area,
                  face_vertex_a, face_vertex_b, face_vertex_c, valid_res,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, tri_area,
                  face_vertex_a, face_vertex_b, face_vertex_c, valid_res,
                  output ready);
endinterface

FILE: rtl/core/mfvn_ram.sv
// mfvn_ram: generic single-write, single-read synchronous RAM
// registered read data; no dependencies
module mfvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mesh_face_and_vertex_normals.sv
// mesh_face_and_vertex_normals: area-weighted face and vertex normals, fixed point
// depends on mfvn_pkg, mfvn_in_if / mfvn_out_if and mfvn_ram
//
// One request is worked at a time and gives one result. Add face and read
// vertex use a shared 20x20 multiplier, one partial product at a time (6
// products for the cross product, 9 for the squared length); the square root
// resolves one bit a cycle and the divider one quotient bit a cycle for each
// of three components. A degenerate face skips the divider, and read vertex
// skips the normalisation for a vertex no face touched. Add face then does
// read-modify-write of the three corner accumulators. After reset the
// accumulator memory is swept to zero, one vertex a cycle, before the first
// request is taken. A result waiting in the output register does not stop the
// next request from being taken.
module mesh_face_and_vertex_normals #(
  parameter int MAX_VERTICES = mfvn_pkg::DEF_MAX_VERTICES,
  parameter int MAX_FACES    = mfvn_pkg::DEF_MAX_FACES,
  parameter int COORD_BITS   = mfvn_pkg::DEF_COORD_BITS
) (
  input logic      clk,
  input logic      rst_n,
  mfvn_in_if.sink  in_ch,
  mfvn_out_if.source out_ch
);
  import mfvn_pkg::*;

  localparam int VAW       = $clog2(MAX_VERTICES);
  localparam int FAW       = $clog2(MAX_FACES);
  localparam int PW        = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int E_W       = COORD_W + 1;
  localparam int POS_WORD  = 3 * COORD_W;
  localparam int ACC_WORD  = 3 * ACC_W + 1;
  localparam int FACE_WORD = 3 * NORM_W + AREA_W + 3 * CORNER_W;

  // helpers
  function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] r;
    r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    return r;
  endfunction

  function automatic logic [E_W-1:0] mag_e(input logic signed [E_W-1:0] v);
    logic [E_W-1:0] r;
    r = v[E_W-1] ? E_W'(-v) : E_W'(v);
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // control state
  state_t state_r, state_nxt;
  logic [VAW-1:0] clr_r;
  logic           out_valid_r;
  logic           out_load;

  // request registers
  cmd_t                cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CORNER_W-1:0] corner_r [3];

  // datapath registers
  logic signed [COORD_W-1:0] pa_r [3];
  logic signed [COORD_W-1:0] pb_r [3];
  logic signed [E_W-1:0]     e1_r [3];
  logic signed [E_W-1:0]     e2_r [3];
  logic signed [ACC_W-1:0]   cvec_r [3];
  logic [1:0]                comp_r;
  logic [1:0]                part_r;
  logic [2*MUL_W-1:0]        prod_r;
  logic                      neg_r;
  logic [SUM_W-1:0]          sum_r;
  logic [SUM_W-1:0]          rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [ACC_W-1:0]          root_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [ACC_W-1:0]          len_r;
  logic [DIV_W-1:0]          drem_r;
  logic [DIV_W-1:0]          dden_r;
  logic [Q_W-1:0]            q_r;
  logic                      sneg_r;
  logic [NORM_W-1:0]         u_r [3];

  // pending result and output registers
  logic [NORM_W-1:0]   rn_r [3];
  logic [AREA_W-1:0]   rarea_r;
  logic [CORNER_W-1:0] rcorner_r [3];
  logic                rvalid_r;
  logic [NORM_W-1:0]   on_r [3];
  logic [AREA_W-1:0]   oarea_r;
  logic [CORNER_W-1:0] ocorner_r [3];
  logic                ovalid_r;

  // memory ports
  logic                 pos_we, acc_we, face_we;
  logic [VAW-1:0]       pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [FAW-1:0]       face_addr;
  logic [POS_WORD-1:0]  pos_wdata, pos_rdata;
  logic [ACC_WORD-1:0]  acc_wdata, acc_rdata;
  logic [FACE_WORD-1:0] face_wdata, face_rdata;

  mfvn_ram #(.WIDTH(POS_WORD), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  mfvn_ram #(.WIDTH(ACC_WORD), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  mfvn_ram #(.WIDTH(FACE_WORD), .DEPTH(MAX_FACES)) u_face_ram (
    .clk(clk), .we(face_we), .waddr(face_addr), .wdata(face_wdata),
    .raddr(face_addr), .rdata(face_rdata)
  );

  // request decode
  logic accept, in_vok, in_fok, in_cok;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_vok      = 32'(in_ch.index) < MAX_VERTICES;
  assign in_fok      = 32'(in_ch.index) < MAX_FACES;
  assign in_cok      = (32'(in_ch.corner_a) < MAX_VERTICES) &&
                       (32'(in_ch.corner_b) < MAX_VERTICES) &&
                       (32'(in_ch.corner_c) < MAX_VERTICES);

  // multiplier operand selection
  logic [1:0]            i1, i2;
  logic signed [E_W-1:0] ea, eb;
  logic [ACC_W-1:0]      msq;
  logic [MUL_W-1:0]      ma, mb;
  logic                  mneg;

  always_comb begin
    i1   = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
    i2   = (comp_r == 2'd0) ? 2'd2 : comp_r - 2'd1;
    ea   = (part_r == 2'd0) ? e1_r[i1] : e1_r[i2];
    eb   = (part_r == 2'd0) ? e2_r[i2] : e2_r[i1];
    msq  = mag_acc(cvec_r[comp_r]);
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (state_r)
      S_XMUL: begin
        ma   = MUL_W'(mag_e(ea));
        mb   = MUL_W'(mag_e(eb));
        mneg = ea[E_W-1] ^ eb[E_W-1] ^ part_r[0];
      end
      S_QMUL: begin
        case (part_r)
          2'd0:    begin ma = msq[MUL_W-1:0];     mb = msq[MUL_W-1:0]; end
          2'd1:    begin ma = msq[MUL_W-1:0];     mb = msq[ACC_W-1:MUL_W]; end
          default: begin ma = msq[ACC_W-1:MUL_W]; mb = msq[ACC_W-1:MUL_W]; end
        endcase
      end
      default: ;
    endcase
  end

  // square root step: two radicand bits a cycle
  logic [REM_W+1:0]   sq_rem2;
  logic [REM_W+2:0]   sq_diff;
  logic [ACC_W-1:0]   root_nxt;
  logic [REM_W-1:0]   rem_nxt;
  logic               sq_last;

  always_comb begin
    sq_rem2 = {rem_r, rad_r[SUM_W-1 -: 2]};
    sq_diff = {1'b0, sq_rem2} - {2'b00, root_r, 2'b01};
    if (sq_diff[REM_W+2]) begin
      rem_nxt  = REM_W'(sq_rem2);
      root_nxt = {root_r[ACC_W-2:0], 1'b0};
    end else begin
      rem_nxt  = REM_W'(sq_diff);
      root_nxt = {root_r[ACC_W-2:0], 1'b1};
    end
    sq_last = (cnt_r == CNT_W'(ACC_W - 1));
  end

  // divider step: one quotient bit a cycle
  logic [DIV_W:0]   dv_diff;
  logic [Q_W-1:0]   q_nxt;
  logic             dv_last;
  logic [DIV_W-1:0] dv_rem_nxt;

  always_comb begin
    dv_diff = {1'b0, drem_r} - {1'b0, dden_r};
    if (dv_diff[DIV_W]) begin
      q_nxt      = {q_r[Q_W-2:0], 1'b0};
      dv_rem_nxt = drem_r;
    end else begin
      q_nxt      = {q_r[Q_W-2:0], 1'b1};
      dv_rem_nxt = dv_diff[DIV_W-1:0];
    end
    dv_last = (cnt_r == CNT_W'(Q_W - 1));
  end

  // accumulator update for one corner
  logic signed [ACC_W-1:0] acc_old [3];
  logic signed [ACC_W-1:0] acc_new [3];
  logic                    acc_touched;

  always_comb begin
    acc_touched = acc_rdata[ACC_WORD-1];
    for (int i = 0; i < 3; i++) begin
      acc_old[i] = acc_rdata[(2-i)*ACC_W +: ACC_W];
      acc_new[i] = sat_add(acc_old[i], cvec_r[i]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == VAW'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_ch.command))
            CMD_ADD_FACE: state_nxt = (in_fok && in_cok) ? S_RDA : S_DONE;
            CMD_RD_VTX:   state_nxt = in_vok ? S_VRD : S_DONE;
            CMD_RD_FACE:  state_nxt = in_fok ? S_FRD : S_DONE;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDC;
      S_RDC:  state_nxt = S_LDC;
      S_LDC:  state_nxt = S_XMUL;
      S_XMUL: state_nxt = S_XACC;
      S_XACC: state_nxt = (comp_r == 2'd2 && part_r == 2'd1) ? S_QMUL : S_XMUL;
      S_QMUL: state_nxt = S_QACC;
      S_QACC: state_nxt = (comp_r == 2'd2 && part_r == 2'd2) ? S_SQI : S_QMUL;
      S_SQI:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (sq_last) state_nxt = (root_nxt == '0) ? S_FIN : S_DVI;
      end
      S_DVI:  state_nxt = S_DIV;
      S_DIV: begin
        if (dv_last) state_nxt = (comp_r == 2'd2) ? S_FIN : S_DVI;
      end
      S_FIN:  state_nxt = (cmd_r == CMD_ADD_FACE) ? S_ARD : S_DONE;
      S_ARD:  state_nxt = S_AWR;
      S_AWR:  state_nxt = (comp_r == 2'd2) ? S_DONE : S_ARD;
      S_VRD:  state_nxt = S_VLD;
      S_VLD:  state_nxt = acc_touched ? S_QMUL : S_DONE;
      S_FRD:  state_nxt = S_FLD;
      S_FLD:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    pos_we     = 1'b0;
    pos_waddr  = VAW'(in_ch.index);
    pos_wdata  = {COORD_W'($signed(in_ch.pos_x[PW-1:0])),
                  COORD_W'($signed(in_ch.pos_y[PW-1:0])),
                  COORD_W'($signed(in_ch.pos_z[PW-1:0]))};
    pos_raddr  = VAW'(corner_r[0]);
    acc_we     = 1'b0;
    acc_waddr  = VAW'(in_ch.index);
    acc_wdata  = '0;
    acc_raddr  = VAW'(idx_r);
    face_we    = 1'b0;
    face_addr  = FAW'(idx_r);
    face_wdata = {u_r[0], u_r[1], u_r[2], len_r[AREA_W:1],
                  corner_r[0], corner_r[1], corner_r[2]};
    case (state_r)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
      end
      S_IDLE: begin
        if (accept && cmd_t'(in_ch.command) == CMD_WR_VTX && in_vok) begin
          pos_we = 1'b1;
          acc_we = 1'b1;
        end
      end
      S_RDB: pos_raddr = VAW'(corner_r[1]);
      S_RDC: pos_raddr = VAW'(corner_r[2]);
      S_FIN: face_we = (cmd_r == CMD_ADD_FACE);
      S_ARD: acc_raddr = VAW'(corner_r[comp_r]);
      S_AWR: begin
        acc_we    = 1'b1;
        acc_waddr = VAW'(corner_r[comp_r]);
        acc_wdata = {1'b1, acc_new[0], acc_new[1], acc_new[2]};
      end
      default: ;
    endcase
  end

  // control registers
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + VAW'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r       <= cmd_t'(in_ch.command);
          idx_r       <= in_ch.index;
          corner_r[0] <= in_ch.corner_a;
          corner_r[1] <= in_ch.corner_b;
          corner_r[2] <= in_ch.corner_c;
          rarea_r     <= '0;
          rvalid_r    <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            rn_r[i]      <= '0;
            rcorner_r[i] <= '0;
          end
        end
      end
      // corner positions and edges
      S_RDB: for (int i = 0; i < 3; i++) pa_r[i] <= pos_rdata[(2-i)*COORD_W +: COORD_W];
      S_RDC: for (int i = 0; i < 3; i++) pb_r[i] <= pos_rdata[(2-i)*COORD_W +: COORD_W];
      S_LDC: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i]   <= E_W'(pb_r[i]) - E_W'(pa_r[i]);
          e2_r[i]   <= E_W'($signed(pos_rdata[(2-i)*COORD_W +: COORD_W])) - E_W'(pa_r[i]);
          cvec_r[i] <= '0;
        end
        comp_r <= 2'd0;
        part_r <= 2'd0;
      end
      S_XMUL, S_QMUL: begin
        prod_r <= ma * mb;
        neg_r  <= mneg;
      end
      // cross product terms
      S_XACC: begin
        cvec_r[comp_r] <= neg_r ? cvec_r[comp_r] - $signed(prod_r)
                                : cvec_r[comp_r] + $signed(prod_r);
        if (part_r == 2'd1) begin
          part_r <= 2'd0;
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end else begin
          part_r <= 2'd1;
        end
        sum_r <= '0;
      end
      // squared length from partial products
      S_QACC: begin
        case (part_r)
          2'd0:    sum_r <= sum_r + SUM_W'(prod_r);
          2'd1:    sum_r <= sum_r + (SUM_W'(prod_r) << (MUL_W + 1));
          default: sum_r <= sum_r + (SUM_W'(prod_r) << (2 * MUL_W));
        endcase
        if (part_r == 2'd2) begin
          part_r <= 2'd0;
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end else begin
          part_r <= part_r + 2'd1;
        end
      end
      S_SQI: begin
        rad_r  <= sum_r;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      S_SQRT: begin
        rad_r  <= rad_r << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
        if (sq_last) begin
          len_r  <= root_nxt;
          comp_r <= 2'd0;
          for (int i = 0; i < 3; i++) u_r[i] <= '0;
        end
      end
      // rounded quotient of one component by the length
      S_DVI: begin
        drem_r <= (DIV_W'(msq) << (Q_W - 1)) + DIV_W'(len_r >> 1);
        dden_r <= DIV_W'(len_r) << (Q_W - 1);
        q_r    <= '0;
        cnt_r  <= '0;
        sneg_r <= cvec_r[comp_r][ACC_W-1];
      end
      S_DIV: begin
        drem_r <= dv_rem_nxt;
        dden_r <= dden_r >> 1;
        q_r    <= q_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
        if (dv_last) begin
          u_r[comp_r] <= sneg_r ? NORM_W'(-NORM_W'(q_nxt)) : NORM_W'(q_nxt);
          comp_r      <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
      end
      S_FIN: begin
        for (int i = 0; i < 3; i++) rn_r[i] <= u_r[i];
        comp_r <= 2'd0;
        if (cmd_r == CMD_ADD_FACE) begin
          rarea_r  <= len_r[AREA_W:1];
          rvalid_r <= (u_r[0] != '0) || (u_r[1] != '0) || (u_r[2] != '0);
          for (int i = 0; i < 3; i++) rcorner_r[i] <= corner_r[i];
        end else begin
          rvalid_r <= (len_r != '0);
        end
      end
      S_AWR: comp_r <= comp_r + 2'd1;
      // touched vertex: accumulator becomes the vector to normalise
      S_VLD: begin
        for (int i = 0; i < 3; i++) cvec_r[i] <= acc_old[i];
        comp_r <= 2'd0;
        part_r <= 2'd0;
        sum_r  <= '0;
      end
      S_FLD: begin
        for (int i = 0; i < 3; i++) begin
          rn_r[i]      <= face_rdata[FACE_WORD-1-i*NORM_W -: NORM_W];
          rcorner_r[i] <= face_rdata[(2-i)*CORNER_W +: CORNER_W];
        end
        rarea_r  <= face_rdata[3*CORNER_W +: AREA_W];
        rvalid_r <= face_rdata[FACE_WORD-1 -: 3*NORM_W] != '0;
      end
      default: ;
    endcase
    // output register
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        on_r[i]      <= rn_r[i];
        ocorner_r[i] <= rcorner_r[i];
      end
      oarea_r  <= rarea_r;
      ovalid_r <= rvalid_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.normal_x      = on_r[0];
  assign out_ch.normal_y      = on_r[1];
  assign out_ch.normal_z      = on_r[2];
  assign out_ch.tri_area      = oarea_r;
  assign out_ch.face_vertex_a = ocorner_r[0];
  assign out_ch.face_vertex_b = ocorner_r[1];
  assign out_ch.face_vertex_c = ocorner_r[2];
  assign out_ch.valid_res     = ovalid_r;

  // checks
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> len_r != '0)
    else $error("divider running with zero length");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted request did not start");

endmodule
